@@ rtl/vau_pkg.sv @@
// Shared types, constants and saturation helpers for the 3D vector ALU.
// Used by every module of the block; depends on nothing.
package vau_pkg;

  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int LANES    = 3;
  localparam int SQRT_LAT = DATA_W;
  localparam int QUO_W    = DATA_W + FRAC_W;
  localparam int DIV_LAT  = QUO_W;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_NEG   = 4'd2,
    MODE_SCALE = 4'd3,
    MODE_DIV   = 4'd4,
    MODE_DOT   = 4'd5,
    MODE_CROSS = 4'd6,
    MODE_PROJ  = 4'd7,
    MODE_REJ   = 4'd8,
    MODE_NORM  = 4'd9
  } mode_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam prod_t VMAX = (prod_t'(1) <<< (DATA_W - 1)) - prod_t'(1);
  localparam prod_t VMIN = -VMAX - prod_t'(1);

  typedef struct packed {
    logic [3:0] mode;
    data_t      ax;
    data_t      ay;
    data_t      az;
    data_t      bx;
    data_t      by;
    data_t      bz;
    data_t      factor;
  } cmd_t;

  typedef struct packed {
    data_t      rx;
    data_t      ry;
    data_t      rz;
    data_t      scalar_out;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic  flag;
    data_t val;
  } sat_t;

  typedef struct packed {
    logic [3:0]            mode;
    data_t [LANES-1:0]     a;
    data_t [LANES-1:0]     b;
    data_t                 fac;
    data_t [LANES-1:0]     r;
    data_t                 scal;
    logic                  satf;
    data_t                 ad;
    data_t                 dd;
    logic                  divz;
    logic [LANES-1:0]      neg;
  } side_t;

  function automatic prod_t wide(input data_t x);
    return prod_t'(x);
  endfunction

  function automatic sat_t sat_data(input prod_t x);
    sat_t s;
    if (x > VMAX) begin
      s.flag = 1'b1;
      s.val  = data_t'(VMAX);
    end else if (x < VMIN) begin
      s.flag = 1'b1;
      s.val  = data_t'(VMIN);
    end else begin
      s.flag = 1'b0;
      s.val  = data_t'(x);
    end
    return s;
  endfunction

endpackage

@@ rtl/vector3_arithmetic_unit.sv @@
// 3D vector ALU in signed Q16.16: add, subtract, negate, scale, divide, dot,
// cross, project, reject and normalise. One beat is accepted every cycle
// while the pipeline is not held, and every beat passes through the 32-stage
// square-root pipeline and the 48-stage quotient pipeline. The pipeline
// holds while the result register is stalled;
// the input register still takes one more beat during such a stall.
// Top level; depends on vau_pkg, vau_lane_mul, vau_sqrt and vau_div_lane.
module vector3_arithmetic_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  vau_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output vau_pkg::res_t res
);
  import vau_pkg::*;

  localparam int VLEN = SQRT_LAT + DIV_LAT + 5;

  logic            adv;
  logic            v0;
  cmd_t            s0;
  logic [VLEN-1:0] vline;

  data_t av [LANES];
  data_t bv [LANES];
  prod_t pp [LANES];
  prod_t qq [LANES];

  cmd_t  c1;
  data_t a1 [LANES];
  data_t b1 [LANES];

  side_t             side2, side2_next;
  logic [PROD_W-1:0] ss, ss_next;
  side_t             sq_line [SQRT_LAT];
  logic [DATA_W-1:0] sq_root;

  logic [QUO_W-1:0]  ds_num [LANES];
  logic [QUO_W-1:0]  ds_num_next [LANES];
  logic [DATA_W-1:0] ds_den [LANES];
  logic [DATA_W-1:0] ds_den_next [LANES];
  side_t             ds_side, ds_side_next;
  side_t             dv_line [DIV_LAT];
  logic [QUO_W-1:0]  dv_quo [LANES];

  sat_t             q_sat [LANES];
  data_t            q_val [LANES];
  logic [LANES-1:0] q_flag;
  side_t            q_side;

  prod_t            p_prod [LANES];
  data_t            p_val [LANES];
  logic [LANES-1:0] p_flag;
  side_t            p_side;

  res_t res_next;

  assign adv       = !res_valid || !res_stall;
  assign cmd_stall = v0 && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      vline     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (adv || !v0) begin
        v0 <= cmd_valid;
      end
      if (adv) begin
        vline     <= {vline[VLEN-2:0], v0};
        res_valid <= vline[VLEN-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv || !v0) begin
      s0 <= cmd;
    end
  end

  assign av[0] = s0.ax;
  assign av[1] = s0.ay;
  assign av[2] = s0.az;
  assign bv[0] = s0.bx;
  assign bv[1] = s0.by;
  assign bv[2] = s0.bz;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vau_lane_mul u_mul (
      .clk    (clk),
      .en     (adv),
      .mode   (s0.mode),
      .a_own  (av[i]),
      .b_own  (bv[i]),
      .a_nxt  (av[(i + 1) % LANES]),
      .a_far  (av[(i + 2) % LANES]),
      .b_nxt  (bv[(i + 1) % LANES]),
      .b_far  (bv[(i + 2) % LANES]),
      .factor (s0.factor),
      .p      (pp[i]),
      .q      (qq[i])
    );

    vau_div_lane u_div (
      .clk (clk),
      .en  (adv),
      .num (ds_num[i]),
      .den (ds_den[i]),
      .quo (dv_quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= s0;
    end
  end

  assign a1[0] = c1.ax;
  assign a1[1] = c1.ay;
  assign a1[2] = c1.az;
  assign b1[0] = c1.bx;
  assign b1[1] = c1.by;
  assign b1[2] = c1.bz;

  // merge the lane products and form the per-mode result and saturation flag
  always_comb begin
    prod_t sum_p;
    prod_t sum_q;
    sat_t  dot_p;
    sat_t  dot_q;
    sat_t  add_s [LANES];
    sat_t  sub_s [LANES];
    sat_t  neg_s [LANES];
    sat_t  scl_s [LANES];
    sat_t  crs_s [LANES];
    logic  add_f, sub_f, neg_f, scl_f, crs_f;

    sum_p   = '0;
    sum_q   = '0;
    ss_next = '0;
    add_f   = 1'b0;
    sub_f   = 1'b0;
    neg_f   = 1'b0;
    scl_f   = 1'b0;
    crs_f   = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      sum_p    = sum_p + (pp[i] >>> FRAC_W);
      sum_q    = sum_q + (qq[i] >>> FRAC_W);
      ss_next  = ss_next + pp[i];
      add_s[i] = sat_data(wide(a1[i]) + wide(b1[i]));
      sub_s[i] = sat_data(wide(a1[i]) - wide(b1[i]));
      neg_s[i] = sat_data(-wide(a1[i]));
      scl_s[i] = sat_data(pp[i] >>> FRAC_W);
      crs_s[i] = sat_data((pp[i] >>> FRAC_W) - (qq[i] >>> FRAC_W));
      add_f    = add_f | add_s[i].flag;
      sub_f    = sub_f | sub_s[i].flag;
      neg_f    = neg_f | neg_s[i].flag;
      scl_f    = scl_f | scl_s[i].flag;
      crs_f    = crs_f | crs_s[i].flag;
    end
    dot_p = sat_data(sum_p);
    dot_q = sat_data(sum_q);

    side2_next      = '0;
    side2_next.mode = c1.mode;
    side2_next.fac  = c1.factor;
    side2_next.ad   = dot_p.val;
    side2_next.dd   = dot_q.val;
    for (int i = 0; i < LANES; i++) begin
      side2_next.a[i] = a1[i];
      side2_next.b[i] = b1[i];
    end

    unique case (c1.mode) inside
      MODE_ADD: begin
        for (int i = 0; i < LANES; i++) side2_next.r[i] = add_s[i].val;
        side2_next.satf = add_f;
      end
      MODE_SUB: begin
        for (int i = 0; i < LANES; i++) side2_next.r[i] = sub_s[i].val;
        side2_next.satf = sub_f;
      end
      MODE_NEG: begin
        for (int i = 0; i < LANES; i++) side2_next.r[i] = neg_s[i].val;
        side2_next.satf = neg_f;
      end
      MODE_SCALE: begin
        for (int i = 0; i < LANES; i++) side2_next.r[i] = scl_s[i].val;
        side2_next.satf = scl_f;
      end
      MODE_CROSS: begin
        for (int i = 0; i < LANES; i++) side2_next.r[i] = crs_s[i].val;
        side2_next.satf = crs_f;
      end
      MODE_DOT: begin
        side2_next.scal = dot_p.val;
        side2_next.satf = dot_p.flag;
      end
      MODE_PROJ, MODE_REJ: side2_next.satf = dot_p.flag | dot_q.flag;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2 <= side2_next;
      ss    <= ss_next;
    end
  end

  vau_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .val  (ss),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_line[0] <= side2;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sq_line[k] <= sq_line[k-1];
      end
    end
  end

  // divider operand set-up
  always_comb begin
    side_t             sd;
    logic [DATA_W-1:0] dmag;
    logic              dneg;
    data_t             nv [LANES];
    logic [DATA_W-1:0] nabs;

    sd   = sq_line[SQRT_LAT-1];
    dmag = '0;
    dneg = 1'b0;
    for (int i = 0; i < LANES; i++) nv[i] = '0;
    ds_side_next      = sd;
    ds_side_next.divz = 1'b0;

    unique case (sd.mode) inside
      MODE_DIV: begin
        dneg = sd.fac[DATA_W-1];
        dmag = dneg ? (~sd.fac + 1'b1) : sd.fac;
        ds_side_next.divz = sd.fac == '0;
        for (int i = 0; i < LANES; i++) nv[i] = sd.a[i];
      end
      MODE_PROJ, MODE_REJ: begin
        dmag = sd.dd;
        ds_side_next.divz = sd.dd == '0;
        for (int i = 0; i < LANES; i++) nv[i] = sd.ad;
      end
      MODE_NORM: begin
        dmag = sq_root;
        ds_side_next.divz = sq_root == '0;
        for (int i = 0; i < LANES; i++) nv[i] = sd.a[i];
      end
      default: ;
    endcase

    for (int i = 0; i < LANES; i++) begin
      nabs                    = nv[i][DATA_W-1] ? (~nv[i] + 1'b1) : nv[i];
      ds_num_next[i]          = {nabs, {FRAC_W{1'b0}}};
      ds_den_next[i]          = dmag;
      ds_side_next.neg[i]     = nv[i][DATA_W-1] ^ dneg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_side <= ds_side_next;
      for (int i = 0; i < LANES; i++) begin
        ds_num[i] <= ds_num_next[i];
        ds_den[i] <= ds_den_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_line[0] <= ds_side;
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_line[k] <= dv_line[k-1];
      end
    end
  end

  always_comb begin
    prod_t qv;
    for (int i = 0; i < LANES; i++) begin
      qv       = dv_line[DIV_LAT-1].neg[i] ? -prod_t'(dv_quo[i]) : prod_t'(dv_quo[i]);
      q_sat[i] = sat_data(qv);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_side <= dv_line[DIV_LAT-1];
      for (int i = 0; i < LANES; i++) begin
        q_val[i]  <= q_sat[i].val;
        q_flag[i] <= q_sat[i].flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_side <= q_side;
      p_flag <= q_flag;
      for (int i = 0; i < LANES; i++) begin
        p_val[i]  <= q_val[i];
        p_prod[i] <= wide(q_val[0]) * wide(q_side.b[i]);
      end
    end
  end

  always_comb begin
    sat_t              pr [LANES];
    sat_t              rj [LANES];
    logic              pr_f;
    logic              rj_f;
    logic              satf;
    data_t [LANES-1:0] rr;

    pr_f = 1'b0;
    rj_f = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      pr[i] = sat_data(p_prod[i] >>> FRAC_W);
      rj[i] = sat_data(wide(p_side.a[i]) - wide(pr[i].val));
      pr_f  = pr_f | pr[i].flag;
      rj_f  = rj_f | rj[i].flag;
    end
    satf = p_side.satf;
    rr   = p_side.r;

    unique case (p_side.mode) inside
      MODE_DIV, MODE_NORM: begin
        for (int i = 0; i < LANES; i++) rr[i] = p_val[i];
        satf = satf | (|p_flag);
      end
      MODE_PROJ: begin
        for (int i = 0; i < LANES; i++) rr[i] = pr[i].val;
        satf = satf | p_flag[0] | pr_f;
      end
      MODE_REJ: begin
        for (int i = 0; i < LANES; i++) rr[i] = rj[i].val;
        satf = satf | p_flag[0] | pr_f | rj_f;
      end
      default: ;
    endcase

    if (p_side.divz) begin
      res_next        = '0;
      res_next.status = ST_DIVZ;
    end else begin
      res_next.rx         = rr[0];
      res_next.ry         = rr[1];
      res_next.rz         = rr[2];
      res_next.scalar_out = p_side.scal;
      res_next.status     = satf ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

@@ rtl/vau_lane_mul.sv @@
// One lane of the front multiplier stage: selects operands by mode and
// forms two registered full-width products. Depends on vau_pkg.
module vau_lane_mul (
  input  logic           clk,
  input  logic           en,
  input  logic [3:0]     mode,
  input  vau_pkg::data_t a_own,
  input  vau_pkg::data_t b_own,
  input  vau_pkg::data_t a_nxt,
  input  vau_pkg::data_t a_far,
  input  vau_pkg::data_t b_nxt,
  input  vau_pkg::data_t b_far,
  input  vau_pkg::data_t factor,
  output vau_pkg::prod_t p,
  output vau_pkg::prod_t q
);
  import vau_pkg::*;

  data_t pa, pb, qa, qb;

  always_comb begin
    pa = a_own;
    pb = b_own;
    qa = b_own;
    qb = b_own;
    unique case (mode) inside
      MODE_SCALE: pb = factor;
      MODE_CROSS: begin
        pa = a_nxt;
        pb = b_far;
        qa = a_far;
        qb = b_nxt;
      end
      MODE_NORM: pb = a_own;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= wide(pa) * wide(pb);
      q <= wide(qa) * wide(qb);
    end
  end

endmodule

@@ rtl/vau_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on vau_pkg.
module vau_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vau_pkg::PROD_W-1:0]  val,
  output logic [vau_pkg::DATA_W-1:0]  root
);
  import vau_pkg::*;

  localparam int REM_W = DATA_W + 2;

  logic [REM_W-1:0]  rem  [SQRT_LAT];
  logic [DATA_W-1:0] rt   [SQRT_LAT];
  logic [PROD_W-1:0] rest [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    logic [REM_W-1:0]  s_rem;
    logic [DATA_W-1:0] s_rt;
    logic [PROD_W-1:0] s_rest;
    logic [REM_W+1:0]  shifted;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign s_rem  = '0;
      assign s_rt   = '0;
      assign s_rest = val;
    end else begin : g_next
      assign s_rem  = rem[k-1];
      assign s_rt   = rt[k-1];
      assign s_rest = rest[k-1];
    end

    assign shifted = {s_rem, s_rest[PROD_W-1 -: 2]};
    assign trial   = {2'b00, s_rt, 2'b01};
    assign ge      = shifted >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? REM_W'(shifted - trial) : REM_W'(shifted);
        rt[k]   <= {s_rt[DATA_W-2:0], ge};
        rest[k] <= s_rest << 2;
      end
    end
  end

  assign root = rt[SQRT_LAT-1];

endmodule

@@ rtl/vau_div_lane.sv @@
// Pipelined restoring divider for one lane: unsigned magnitudes,
// one quotient bit per stage. Depends on vau_pkg.
module vau_div_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vau_pkg::QUO_W-1:0]  num,
  input  logic [vau_pkg::DATA_W-1:0] den,
  output logic [vau_pkg::QUO_W-1:0]  quo
);
  import vau_pkg::*;

  logic [DATA_W-1:0] rem [DIV_LAT];
  logic [QUO_W-1:0]  nq  [DIV_LAT];
  logic [DATA_W-1:0] dn  [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [DATA_W-1:0] s_rem;
    logic [QUO_W-1:0]  s_nq;
    logic [DATA_W-1:0] s_dn;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign s_rem = '0;
      assign s_nq  = num;
      assign s_dn  = den;
    end else begin : g_next
      assign s_rem = rem[k-1];
      assign s_nq  = nq[k-1];
      assign s_dn  = dn[k-1];
    end

    assign trial = {s_rem, s_nq[QUO_W-1]};
    assign diff  = trial - {1'b0, s_dn};
    assign ge    = trial >= {1'b0, s_dn};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        nq[k]  <= {s_nq[QUO_W-2:0], ge};
        dn[k]  <= s_dn;
      end
    end
  end

  assign quo = nq[DIV_LAT-1];

endmodule

@@ rtl/vau_check.sv @@
// Port-level checks for the 3D vector ALU, bound to the top level.
// Depends on vau_pkg and vector3_arithmetic_unit.
module vau_check (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input logic          res_valid,
  input logic          res_stall,
  input vau_pkg::res_t res
);
  import vau_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |-> res_valid && res_stall)
    else $error("input stalled without a blocked result");

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_DIVZ |->
      res.rx == '0 && res.ry == '0 && res.rz == '0 && res.scalar_out == '0)
    else $error("division by zero beat carries data");

  a_dot_alone: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.scalar_out != '0 |->
      res.rx == '0 && res.ry == '0 && res.rz == '0)
    else $error("scalar and vector result both set");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid straight after reset");

endmodule

bind vector3_arithmetic_unit vau_check u_vau_check (.*);

@@ verif/vau_checker.sv @@
// Checker for the 3D vector ALU: watches the cmd and res channels, predicts
// each result beat and compares it field by field. Depends on vau_pkg.
module vau_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_stall,
  input  vau_pkg::cmd_t cmd,
  input  logic          res_valid,
  input  logic          res_stall,
  input  vau_pkg::res_t res,
  output int            errors,
  output int            pending
);
  import vau_pkg::*;

  res_t expected_q[$];
  bit   clamped;

  function automatic longint clamp(input longint x);
    longint hi, lo;
    hi = (64'sd1 <<< (DATA_W - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      clamped = 1;
      return hi;
    end
    if (x < lo) begin
      clamped = 1;
      return lo;
    end
    return x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC_W;
  endfunction

  function automatic longint qdiv(input longint n, input longint d);
    return clamp((n * (64'sd1 <<< FRAC_W)) / d);
  endfunction

  function automatic longint qdot(input longint a[3], input longint b[3]);
    return clamp(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2]));
  endfunction

  function automatic longint floor_root(input logic [63:0] v);
    logic [63:0] acc, bit_w;
    acc   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= acc + bit_w) begin
        v   = v - (acc + bit_w);
        acc = (acc >> 1) + bit_w;
      end else begin
        acc = acc >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return longint'(acc);
  endfunction

  function automatic res_t vector_result(input cmd_t c);
    longint a[3], b[3], r[3], s, scal, t, dd, ad, p, m;
    logic [63:0] sq;
    bit divz;
    res_t o;
    a = '{longint'(c.ax), longint'(c.ay), longint'(c.az)};
    b = '{longint'(c.bx), longint'(c.by), longint'(c.bz)};
    r = '{0, 0, 0};
    s = longint'(c.factor);
    scal = 0;
    divz = 0;
    clamped = 0;
    case (c.mode)
      MODE_ADD:   for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + b[i]);
      MODE_SUB:   for (int i = 0; i < 3; i++) r[i] = clamp(a[i] - b[i]);
      MODE_NEG:   for (int i = 0; i < 3; i++) r[i] = clamp(-a[i]);
      MODE_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp(qmul(a[i], s));
      MODE_DIV: begin
        if (s == 0) divz = 1;
        else for (int i = 0; i < 3; i++) r[i] = qdiv(a[i], s);
      end
      MODE_DOT: scal = qdot(a, b);
      MODE_CROSS: begin
        r[0] = clamp(qmul(a[1], b[2]) - qmul(a[2], b[1]));
        r[1] = clamp(qmul(a[2], b[0]) - qmul(a[0], b[2]));
        r[2] = clamp(qmul(a[0], b[1]) - qmul(a[1], b[0]));
      end
      MODE_PROJ, MODE_REJ: begin
        dd = qdot(b, b);
        ad = qdot(a, b);
        if (dd == 0) divz = 1;
        else begin
          t = qdiv(ad, dd);
          for (int i = 0; i < 3; i++) begin
            p = clamp(qmul(b[i], t));
            r[i] = (c.mode == MODE_PROJ) ? p : clamp(a[i] - p);
          end
        end
      end
      MODE_NORM: begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + 64'(a[i] * a[i]);
        m = floor_root(sq);
        if (m == 0) divz = 1;
        else for (int i = 0; i < 3; i++) r[i] = qdiv(a[i], m);
      end
      default: ;
    endcase
    if (divz) begin
      r = '{0, 0, 0};
      scal = 0;
    end
    o.rx = data_t'(r[0]);
    o.ry = data_t'(r[1]);
    o.rz = data_t'(r[2]);
    o.scalar_out = data_t'(scal);
    o.status = divz ? ST_DIVZ : (clamped ? ST_SAT : ST_OK);
    return o;
  endfunction

  assign pending = expected_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    res_t e;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) expected_q.push_back(vector_result(cmd));
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result beat %h", $time, res);
        end else begin
          e = expected_q.pop_front();
          if (e.rx !== res.rx || e.ry !== res.ry || e.rz !== res.rz ||
              e.scalar_out !== res.scalar_out || e.status !== res.status) begin
            errors <= errors + 1;
            $display("%0t: mismatch expected r=(%h,%h,%h) s=%h st=%0d", $time,
                     e.rx, e.ry, e.rz, e.scalar_out, e.status);
            $display("%0t:          actual   r=(%h,%h,%h) s=%h st=%0d", $time,
                     res.rx, res.ry, res.rz, res.scalar_out, res.status);
          end
        end
      end
    end
  end
endmodule

@@ verif/vector3_arithmetic_unit_tb.sv @@
// Testbench top for the 3D vector ALU: drives directed and random beats with
// random idling and back-pressure. Needs vau_pkg, vau_checker, the ALU top.
module vector3_arithmetic_unit_tb;
  import vau_pkg::*;

  logic clk, rst, cmd_valid, cmd_stall, res_valid, res_stall;
  cmd_t cmd;
  res_t res;
  int   errors, pending, cycles;
  bit   calm, hold_off;

  vector3_arithmetic_unit uut (.*);
  vau_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic data_t corner();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return 32'sh00010000;
      4: return 32'shffff0000;
      5: return data_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      6: return data_t'($urandom_range(0, 32'hfff)) - 32'sh800;
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
    c.ax = corner(); c.ay = corner(); c.az = corner();
    c.bx = corner(); c.by = corner(); c.bz = corner();
    c.factor = corner();
    if ($urandom_range(0, 9) == 0) {c.bx, c.by, c.bz} = '0;
    if ($urandom_range(0, 9) == 0) {c.ax, c.ay, c.az} = '0;
    return c;
  endfunction

  task automatic send(input cmd_t c);
    while (!calm && $urandom_range(0, 99) < 18) begin
      cmd_valid <= 0;
      @(negedge clk);
    end
    cmd_valid <= 1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off) res_stall <= 1;
    else res_stall <= !calm && ($urandom_range(0, 99) < 18);
  end

  initial begin
    cmd_t c;
    data_t v[6];
    rst = 1; cmd_valid = 0; cmd = '0; res_stall = 0; calm = 0; hold_off = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    v = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh00010000, 32'shffff0000, 32'sh00028000};
    for (int m = 0; m < 16; m++) begin
      c.mode = 4'(m);
      c.ax = v[m % 6]; c.ay = v[(m + 1) % 6]; c.az = v[(m + 2) % 6];
      c.bx = v[(m + 3) % 6]; c.by = v[(m + 4) % 6]; c.bz = v[(m + 5) % 6];
      c.factor = v[m % 6];
      send(c);
    end
    c = '0; c.mode = MODE_DIV; c.ax = 32'sh00010000; send(c);
    c.mode = MODE_PROJ; send(c);
    c.mode = MODE_REJ; send(c);
    c.mode = MODE_NORM; c.ax = 0; send(c);
    c = '1; c.mode = MODE_ADD; send(c);
    c = '0; c.mode = MODE_NEG; c.ax = 32'sh80000000; send(c);
    drain();
    for (int i = 0; i < 750; i++) begin
      if (i == 200) calm = 1;
      if (i == 300) calm = 0;
      if (i == 400) begin
        fork
          begin
            hold_off = 1;
            repeat (300) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      if (i == 600) drain();
      send(rand_cmd());
    end
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
